// ===== sv/igb_pkg.sv =====
`timescale 1ns / 1ps
package igb_pkg;

  localparam int MAX_X_NODES = 32;
  localparam int MAX_Y_NODES = 32;
  localparam int XI_W        = $clog2(MAX_X_NODES);
  localparam int YI_W        = $clog2(MAX_Y_NODES);
  localparam int CELLS       = MAX_X_NODES * MAX_Y_NODES;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int CNT_W       = 6;

  localparam logic [2:0] FUNC_LDX  = 3'd0;
  localparam logic [2:0] FUNC_LDY  = 3'd1;
  localparam logic [2:0] FUNC_ACC  = 3'd2;
  localparam logic [2:0] FUNC_READ = 3'd3;
  localparam logic [2:0] FUNC_CLR  = 3'd4;

  localparam logic CFG_X_USED = 1'b0;
  localparam logic CFG_Y_USED = 1'b1;

  typedef struct packed {
    logic [2:0]         func;
    logic [4:0]         node_index;
    logic signed [31:0] node_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
  } igb_in_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               cell_empty;
  } igb_out_t;

  typedef logic [4:0] igb_op_t;

  localparam igb_op_t OP_NONE      = 5'd0;
  localparam igb_op_t OP_LATCH     = 5'd1;
  localparam igb_op_t OP_NODE_WR   = 5'd2;
  localparam igb_op_t OP_RD0       = 5'd3;
  localparam igb_op_t OP_RD1       = 5'd4;
  localparam igb_op_t OP_SPDIV     = 5'd5;
  localparam igb_op_t OP_MULQ      = 5'd6;
  localparam igb_op_t OP_SQ        = 5'd7;
  localparam igb_op_t OP_SCAN_INIT = 5'd8;
  localparam igb_op_t OP_SCAN      = 5'd9;
  localparam igb_op_t OP_MULB      = 5'd10;
  localparam igb_op_t OP_TDIV      = 5'd11;
  localparam igb_op_t OP_TADD      = 5'd12;
  localparam igb_op_t OP_WDIV      = 5'd13;
  localparam igb_op_t OP_ZDIV      = 5'd14;
  localparam igb_op_t OP_ACCRD     = 5'd15;
  localparam igb_op_t OP_ACCWR     = 5'd16;
  localparam igb_op_t OP_CRD       = 5'd17;
  localparam igb_op_t OP_CCHK      = 5'd18;
  localparam igb_op_t OP_OUT       = 5'd19;
  localparam igb_op_t OP_CLR       = 5'd20;

  typedef struct packed {
    igb_op_t op;
    logic    axis;
  } igb_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       div_done;
    logic       scan_done;
    logic       cell_empty;
    logic       out_free;
    logic       clr_last;
  } igb_stat_t;

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    begin
      d = $signed({a[31], a}) - $signed({b[31], b});
      m = d[32] ? 33'(-d) : 33'(d);
      return m[31:0];
    end
  endfunction

endpackage

// ===== sv/idw_grid_binning_core.sv =====
`timescale 1ns / 1ps
// Inverse-distance-weighted binning of (x,y,z) samples onto a grid of up to 32x32 cells,
// all values signed Q16.16. One item is in work at a time. A cell read skips the divider
// when the cell is empty or outside the used grid and makes one divider pass otherwise.
// An accumulate makes six passes through the shared radix-2 divider (64 steps each, none
// when the quotient is trivially zero or saturated) plus one node table read per node
// scanned. After reset and for every clear item the accumulator memories are swept at
// one cell per cycle, during which no item is taken; configuration writes are always
// taken. A finished read result waits in the output register while the next item is
// accepted.
module idw_grid_binning_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  igb_pkg::igb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output igb_pkg::igb_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);
  import igb_pkg::*;

  igb_cmd_t  cmd;
  igb_stat_t stat;

  assign cfg_ready = 1'b1;

  igb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  igb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken before accumulator sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> stat.out_free)
    else $error("result register overwritten");

endmodule

// ===== sv/igb_div.sv =====
`timescale 1ns / 1ps
module igb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] den,
  input  logic [63:0] cap,
  output logic        done,
  output logic [63:0] q
);

  logic [63:0] rem_r, num_r, q_r, den_r, cap_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic        carry, ge;
  logic [63:0] sh, diff, q_step;

  // restoring division, one quotient bit per cycle
  always_comb begin
    carry  = rem_r[63];
    sh     = {rem_r[62:0], num_r[63]};
    ge     = carry || (sh >= den_r);
    diff   = sh - den_r;
    q_step = {q_r[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == 64'd0 || hi >= den) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (den == 64'd0) begin
        q_r <= (hi == 64'd0 && lo == 64'd0) ? 64'd0 : cap;
      end else if (hi >= den) begin
        q_r <= cap;
      end else begin
        rem_r <= hi;
        num_r <= lo;
        q_r   <= 64'd0;
        den_r <= den;
        cap_r <= cap;
        cnt_r <= 6'd63;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff : sh;
      num_r <= {num_r[62:0], 1'b0};
      if (cnt_r == 6'd0) begin
        q_r <= (q_step > cap_r) ? cap_r : q_step;
      end else begin
        q_r   <= q_step;
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== sv/igb_ctrl.sv =====
`timescale 1ns / 1ps
module igb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  igb_pkg::igb_stat_t stat,
  output igb_pkg::igb_cmd_t  cmd
);
  import igb_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_SP0    = 5'd3;
  localparam logic [4:0] S_SP1    = 5'd4;
  localparam logic [4:0] S_SPDIV  = 5'd5;
  localparam logic [4:0] S_SPWAIT = 5'd6;
  localparam logic [4:0] S_SPMUL  = 5'd7;
  localparam logic [4:0] S_SPSQ   = 5'd8;
  localparam logic [4:0] S_SCAN0  = 5'd9;
  localparam logic [4:0] S_SCAN   = 5'd10;
  localparam logic [4:0] S_NRMUL  = 5'd11;
  localparam logic [4:0] S_NRDIV  = 5'd12;
  localparam logic [4:0] S_NRWAIT = 5'd13;
  localparam logic [4:0] S_NRADD  = 5'd14;
  localparam logic [4:0] S_WDIV   = 5'd15;
  localparam logic [4:0] S_WWAIT  = 5'd16;
  localparam logic [4:0] S_ZDIV   = 5'd17;
  localparam logic [4:0] S_ZWAIT  = 5'd18;
  localparam logic [4:0] S_ACCRD  = 5'd19;
  localparam logic [4:0] S_ACCWR  = 5'd20;
  localparam logic [4:0] S_CRD    = 5'd21;
  localparam logic [4:0] S_CCHK   = 5'd22;
  localparam logic [4:0] S_RWAIT  = 5'd23;
  localparam logic [4:0] S_RES    = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        axis_nxt = 1'b0;
        unique case (stat.func)
          FUNC_LDX, FUNC_LDY: begin
            cmd.op    = OP_NODE_WR;
            state_nxt = S_IDLE;
          end
          FUNC_ACC:  state_nxt = S_SP0;
          FUNC_READ: state_nxt = S_CRD;
          FUNC_CLR:  state_nxt = S_CLR;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SP0: begin
        cmd.op    = OP_RD0;
        state_nxt = S_SP1;
      end
      S_SP1: begin
        cmd.op    = OP_RD1;
        state_nxt = S_SPDIV;
      end
      S_SPDIV: begin
        cmd.op    = OP_SPDIV;
        state_nxt = S_SPWAIT;
      end
      S_SPWAIT: if (stat.div_done) state_nxt = S_SPMUL;
      S_SPMUL: begin
        cmd.op    = OP_MULQ;
        state_nxt = S_SPSQ;
      end
      S_SPSQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SCAN0;
      end
      S_SCAN0: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_done) state_nxt = S_NRMUL;
      end
      S_NRMUL: begin
        cmd.op    = OP_MULB;
        state_nxt = S_NRDIV;
      end
      S_NRDIV: begin
        cmd.op    = OP_TDIV;
        state_nxt = S_NRWAIT;
      end
      S_NRWAIT: if (stat.div_done) state_nxt = S_NRADD;
      S_NRADD: begin
        cmd.op = OP_TADD;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_SP0;
        end else begin
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        cmd.op    = OP_WDIV;
        state_nxt = S_WWAIT;
      end
      S_WWAIT: if (stat.div_done) state_nxt = S_ZDIV;
      S_ZDIV: begin
        cmd.op    = OP_ZDIV;
        state_nxt = S_ZWAIT;
      end
      S_ZWAIT: if (stat.div_done) state_nxt = S_ACCRD;
      S_ACCRD: begin
        cmd.op    = OP_ACCRD;
        state_nxt = S_ACCWR;
      end
      S_ACCWR: begin
        cmd.op    = OP_ACCWR;
        state_nxt = S_IDLE;
      end
      S_CRD: begin
        cmd.op    = OP_CRD;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        cmd.op    = OP_CCHK;
        state_nxt = stat.cell_empty ? S_RES : S_RWAIT;
      end
      S_RWAIT: if (stat.div_done) state_nxt = S_RES;
      S_RES: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

// ===== sv/igb_dpath.sv =====
`timescale 1ns / 1ps
module igb_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  igb_pkg::igb_cmd_t  cmd,
  output igb_pkg::igb_stat_t stat,
  input  igb_pkg::igb_in_t   in_data,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output igb_pkg::igb_out_t  out_data
);
  import igb_pkg::*;

  function automatic logic [CNT_W-1:0] used_cnt(logic [CNT_W-1:0] r, int mx);
    begin
      if (r < CNT_W'(2)) return CNT_W'(2);
      if (32'(r) > mx) return CNT_W'(mx);
      return r;
    end
  endfunction

  igb_in_t            item_r;
  logic [CNT_W-1:0]   xn_cfg_r, yn_cfg_r, nx, ny, n_sel, raddr;
  logic signed [31:0] xmem [MAX_X_NODES];
  logic signed [31:0] ymem [MAX_Y_NODES];
  logic signed [31:0] xrd_r, yrd_r, rd_sel, first_r, p_sel;
  logic [31:0]        dist_sp, d_scan, best_r, zmag, d2_eff, res_val;
  logic [63:0]        prod_r, sq_x_r, sq_y_r, w_r, mag;
  logic [CNT_W-1:0]   idx_r, tag_r, bidx_r;
  logic               scan_vld_r;
  logic [32:0]        d2acc_r;
  logic [XI_W-1:0]    xi_r;
  logic [YI_W-1:0]    yi_r;
  logic [CELL_W-1:0]  cell_acc, cell_rd, acc_raddr, acc_waddr, clr_addr_r;
  logic signed [63:0] wzmem [CELLS];
  logic [63:0]        wmem [CELLS];
  logic signed [63:0] wzrd_r, wz_new;
  logic [63:0]        wrd_r, w_new;
  logic [64:0]        w_sum;
  logic signed [64:0] wz_sum;
  logic               acc_we, empty_now, empty_r, neg_r;
  logic               div_start, div_done;
  logic [63:0]        div_hi, div_lo, div_den, div_cap, div_q;
  igb_out_t           out_data_r;
  logic               out_valid_r;

  assign nx    = used_cnt(xn_cfg_r, MAX_X_NODES);
  assign ny    = used_cnt(yn_cfg_r, MAX_Y_NODES);
  assign n_sel = cmd.axis ? ny : nx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xn_cfg_r <= CNT_W'(32);
      yn_cfg_r <= CNT_W'(32);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_X_USED) xn_cfg_r <= cfg_data;
      else yn_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) item_r <= in_data;
  end

  // node tables
  always_comb begin
    unique case (cmd.op)
      OP_RD1:  raddr = n_sel - CNT_W'(1);
      OP_SCAN: raddr = idx_r;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    xrd_r <= xmem[XI_W'(raddr)];
    yrd_r <= ymem[YI_W'(raddr)];
    if (cmd.op == OP_NODE_WR) begin
      if (item_r.func == FUNC_LDX && 32'(item_r.node_index) < MAX_X_NODES)
        xmem[XI_W'(item_r.node_index)] <= item_r.node_value;
      if (item_r.func == FUNC_LDY && 32'(item_r.node_index) < MAX_Y_NODES)
        ymem[YI_W'(item_r.node_index)] <= item_r.node_value;
    end
  end

  assign rd_sel  = cmd.axis ? yrd_r : xrd_r;
  assign p_sel   = cmd.axis ? item_r.point_y : item_r.point_x;
  assign dist_sp = abs_diff(rd_sel, first_r);
  assign d_scan  = abs_diff(p_sel, rd_sel);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD1) first_r <= rd_sel;
    if (cmd.op == OP_MULQ) prod_r <= 64'(div_q[31:0]) * 64'(div_q[31:0]);
    if (cmd.op == OP_MULB) prod_r <= 64'(best_r) * 64'(best_r);
    if (cmd.op == OP_SQ) begin
      if (cmd.axis) sq_y_r <= prod_r;
      else sq_x_r <= prod_r;
    end
    if (cmd.op == OP_TADD) begin
      if (cmd.axis) begin
        d2acc_r <= d2acc_r + {1'b0, div_q[31:0]};
        yi_r    <= YI_W'(bidx_r);
      end else begin
        d2acc_r <= {1'b0, div_q[31:0]};
        xi_r    <= XI_W'(bidx_r);
      end
    end
    if (cmd.op == OP_ZDIV) w_r <= div_q;
  end

  // nearest-node scan: one table read per cycle, each compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      scan_vld_r <= 1'b0;
    end else if (cmd.op == OP_SCAN_INIT) begin
      idx_r      <= '0;
      scan_vld_r <= 1'b0;
    end else if (cmd.op == OP_SCAN) begin
      scan_vld_r <= idx_r < n_sel;
      if (idx_r < n_sel) idx_r <= idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN) begin
      tag_r <= idx_r;
      if (scan_vld_r && (tag_r == '0 || d_scan < best_r)) begin
        best_r <= d_scan;
        bidx_r <= tag_r;
      end
    end
  end

  // clamp d2 to one LSB; sum saturates at all ones
  assign d2_eff = d2acc_r[32] ? 32'hFFFF_FFFF :
                  (d2acc_r[31:0] == 32'd0 ? 32'd1 : d2acc_r[31:0]);
  assign zmag   = item_r.point_z[31] ? (~item_r.point_z + 32'd1) : item_r.point_z;
  assign mag    = wzrd_r[63] ? (~wzrd_r + 64'd1) : wzrd_r;

  assign empty_now = (CNT_W'(item_r.cell_x) >= nx) || (CNT_W'(item_r.cell_y) >= ny) ||
                     (wrd_r == 64'd0);

  always_comb begin
    div_start = 1'b1;
    div_hi    = 64'd0;
    div_lo    = 64'd0;
    div_den   = 64'd0;
    div_cap   = '1;
    unique case (cmd.op)
      OP_SPDIV: begin
        div_lo  = 64'(dist_sp);
        div_den = 64'(n_sel);
      end
      OP_TDIV: begin
        div_hi  = prod_r >> 48;
        div_lo  = prod_r << 16;
        div_den = cmd.axis ? sq_y_r : sq_x_r;
        div_cap = 64'hFFFF_FFFF;
      end
      OP_WDIV: begin
        div_lo  = 64'h1_0000_0000;
        div_den = 64'(d2_eff);
      end
      OP_ZDIV: begin
        div_lo  = 64'(zmag) << 16;
        div_den = 64'(d2_eff);
      end
      OP_CCHK: begin
        div_start = !empty_now;
        div_hi    = mag >> 48;
        div_lo    = mag << 16;
        div_den   = wrd_r;
        div_cap   = wzrd_r[63] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      default: div_start = 1'b0;
    endcase
  end

  igb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .den   (div_den),
    .cap   (div_cap),
    .done  (div_done),
    .q     (div_q)
  );

  // accumulator memories
  assign cell_acc  = CELL_W'(xi_r) * CELL_W'(MAX_Y_NODES) + CELL_W'(yi_r);
  assign cell_rd   = CELL_W'(item_r.cell_x) * CELL_W'(MAX_Y_NODES) + CELL_W'(item_r.cell_y);
  assign acc_raddr = (cmd.op == OP_CRD) ? cell_rd : cell_acc;
  assign acc_waddr = (cmd.op == OP_CLR) ? clr_addr_r : cell_acc;
  assign acc_we    = (cmd.op == OP_ACCWR) || (cmd.op == OP_CLR);

  always_comb begin
    w_sum  = {1'b0, wrd_r} + {1'b0, w_r};
    w_new  = w_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sum[63:0];
    wz_sum = item_r.point_z[31] ? ($signed({wzrd_r[63], wzrd_r}) - $signed({1'b0, div_q}))
                                : ($signed({wzrd_r[63], wzrd_r}) + $signed({1'b0, div_q}));
    if (wz_sum[64] != wz_sum[63])
      wz_new = wz_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      wz_new = wz_sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCRD || cmd.op == OP_CRD) begin
      wzrd_r <= wzmem[acc_raddr];
      wrd_r  <= wmem[acc_raddr];
    end
    if (acc_we) begin
      wzmem[acc_waddr] <= (cmd.op == OP_CLR) ? 64'sd0 : wz_new;
      wmem[acc_waddr]  <= (cmd.op == OP_CLR) ? 64'd0 : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.op == OP_CLR) clr_addr_r <= clr_addr_r + CELL_W'(1);
  end

  // read result
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CCHK) begin
      empty_r <= empty_now;
      neg_r   <= wzrd_r[63];
    end
  end

  assign res_val = neg_r ? (~div_q[31:0] + 32'd1) : div_q[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data_r.cell_value <= empty_r ? 32'sd0 : $signed(res_val);
      out_data_r.cell_empty <= empty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.func       = item_r.func;
  assign stat.div_done   = div_done;
  assign stat.scan_done  = (idx_r == n_sel) && !scan_vld_r;
  assign stat.cell_empty = empty_now;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.clr_last   = clr_addr_r == CELL_W'(CELLS - 1);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import igb_pkg::*;

  localparam logic [2:0] FUNC_NOP_LO  = 3'd5;
  localparam logic [2:0] FUNC_NOP_MID = 3'd6;
  localparam logic [2:0] FUNC_NOP_HI  = 3'd7;
  localparam int         CYCLE_LIMIT = 4000000;
  localparam int         SETTLE      = 1500;
  localparam int         RAND_ITEMS  = 290;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint      S64_MIN  = 64'sh8000_0000_0000_0000;
  localparam longint      S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;

  class cell_scoreboard;
    int          x_node [MAX_X_NODES];
    int          y_node [MAX_Y_NODES];
    logic [5:0]  x_used, y_used;
    longint      wz_sum [CELLS];
    logic [63:0] w_sum  [CELLS];
    igb_out_t    pending_reads[$];
    int          errors, reads_checked, accums, clears;
    int          last_xi, last_yi;

    function new();
      x_used = 6'd32;
      y_used = 6'd32;
      foreach (x_node[i]) x_node[i] = 0;
      foreach (y_node[i]) y_node[i] = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      foreach (wz_sum[i]) begin
        wz_sum[i] = 0;
        w_sum[i]  = '0;
      end
    endfunction

    function int eff_count(logic [5:0] r, int max_n);
      if (r < 2) return 2;
      return (r > max_n) ? max_n : int'(r);
    endfunction

    function logic [63:0] abs_dist(int a, int b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
    endfunction

    // floor(num / den) capped; zero divisor gives 0 or the cap
    function logic [63:0] capped_div(logic [127:0] num, logic [63:0] den, logic [63:0] cap);
      logic [127:0] q;
      if (den == 0) return (num == 0) ? 64'd0 : cap;
      if (num[127:64] >= den) return cap;
      q = num / {64'd0, den};
      return (q[63:0] > cap) ? cap : q[63:0];
    endfunction

    function logic [63:0] spacing_sq(bit ax);
      int          n;
      logic [63:0] s;
      n = ax ? eff_count(y_used, MAX_Y_NODES) : eff_count(x_used, MAX_X_NODES);
      s = ax ? abs_dist(y_node[n-1], y_node[0]) / n : abs_dist(x_node[n-1], x_node[0]) / n;
      return s * s;
    endfunction

    // normalized squared offset to the nearest node; lower index wins ties
    function logic [63:0] nearest_term(bit ax, int p, logic [63:0] sq, output int idx);
      int          n;
      logic [63:0] best, d;
      n = ax ? eff_count(y_used, MAX_Y_NODES) : eff_count(x_used, MAX_X_NODES);
      best = abs_dist(p, ax ? y_node[0] : x_node[0]);
      idx = 0;
      for (int i = 1; i < n; i++) begin
        d = abs_dist(p, ax ? y_node[i] : x_node[i]);
        if (d < best) begin
          best = d;
          idx = i;
        end
      end
      d = best * best;
      return capped_div({48'd0, d, 16'd0}, sq, 64'hFFFF_FFFF);
    endfunction

    function void accumulate(int px, int py, int pz);
      logic [63:0] sx, sy, d2, w, zmag, zt;
      logic [64:0] wsum;
      int          xi, yi, c;
      longint      acc;
      sx = spacing_sq(1'b0);
      sy = spacing_sq(1'b1);
      d2 = nearest_term(1'b0, px, sx, xi) + nearest_term(1'b1, py, sy, yi);
      if (d2 > 64'hFFFF_FFFF) d2 = 64'hFFFF_FFFF;
      if (d2 == 0) d2 = 64'd1;
      c = xi * MAX_Y_NODES + yi;
      last_xi = xi;
      last_yi = yi;
      w = (64'd1 << 32) / d2;
      wsum = {1'b0, w_sum[c]} + {1'b0, w};
      w_sum[c] = wsum[64] ? ALL_ONES : wsum[63:0];
      zmag = (pz < 0) ? -longint'(pz) : longint'(pz);
      zt = (zmag << 16) / d2;
      acc = wz_sum[c];
      if (pz < 0) acc = (acc < S64_MIN + longint'(zt)) ? S64_MIN : acc - longint'(zt);
      else acc = (acc > S64_MAX - longint'(zt)) ? S64_MAX : acc + longint'(zt);
      wz_sum[c] = acc;
    endfunction

    function igb_out_t read_cell(logic [4:0] cx, logic [4:0] cy);
      igb_out_t    r;
      int          c;
      logic [63:0] w, mag, q;
      bit          neg;
      r.cell_value = '0;
      r.cell_empty = 1'b1;
      if (cx >= eff_count(x_used, MAX_X_NODES) || cy >= eff_count(y_used, MAX_Y_NODES))
        return r;
      c = int'(cx) * MAX_Y_NODES + int'(cy);
      w = w_sum[c];
      if (w == 0) return r;
      neg = wz_sum[c] < 0;
      mag = neg ? 64'd0 - wz_sum[c] : wz_sum[c];
      q = capped_div({48'd0, mag, 16'd0}, w, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
      if (neg) q = 64'd0 - q;
      r.cell_value = q[31:0];
      r.cell_empty = 1'b0;
      return r;
    endfunction

    function void set_used(logic idx, logic [5:0] v);
      if (idx == CFG_X_USED) x_used = v;
      else y_used = v;
    endfunction

    function void note_item(igb_in_t it);
      case (it.func)
        FUNC_LDX:  x_node[it.node_index] = it.node_value;
        FUNC_LDY:  y_node[it.node_index] = it.node_value;
        FUNC_ACC: begin
          accumulate(it.point_x, it.point_y, it.point_z);
          accums++;
        end
        FUNC_READ: pending_reads.insert(pending_reads.size(),
                                        read_cell(it.cell_x, it.cell_y));
        FUNC_CLR: begin
          clear_sums();
          clears++;
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(igb_out_t got);
      igb_out_t want;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result value=%h empty=%b", got.cell_value,
                         got.cell_empty));
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got.cell_value !== want.cell_value)
        report($sformatf("cell_value got %h want %h", got.cell_value, want.cell_value));
      if (got.cell_empty !== want.cell_empty)
        report($sformatf("cell_empty got %b want %b", got.cell_empty, want.cell_empty));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  igb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  igb_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;

  cell_scoreboard sb = new();
  int  cyc = 0;
  bit  calm;
  int  items_sent = 0;
  int  x_mirror [MAX_X_NODES];
  int  y_mirror [MAX_Y_NODES];

  idw_grid_binning_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // a quiet window where neither side idles
  assign calm = (cyc >= 30000 && cyc < 80000);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("[idw_grid_binning_core] ERROR");
      $finish;
    end
  end

  // result side; one long hold-off lets the block back up into its input
  initial begin
    int rcyc, hold;
    rcyc = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      rcyc++;
      if (rcyc == 120000) hold = 3000;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send(input igb_in_t it);
    if (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic cfg_write(input logic idx, input logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_used(idx, v);
  endtask

  // accumulates give no result, so allow the last one to finish too
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic igb_in_t noise_item(logic [2:0] f);
    igb_in_t      it;
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(igb_in_t)-1:0];
    it.func = f;
    return it;
  endfunction

  task automatic load_node(bit ax, int i, int v);
    igb_in_t it;
    it = noise_item(ax ? FUNC_LDY : FUNC_LDX);
    it.node_index = 5'(i);
    it.node_value = v;
    if (ax) y_mirror[i] = v;
    else x_mirror[i] = v;
    send(it);
  endtask

  // kind 0 evenly spaced, 1 arbitrary, 2 all nodes equal
  task automatic load_grid(int kind, int base, int step);
    for (int ax = 0; ax < 2; ax++)
      for (int i = 0; i < 32; i++)
        case (kind)
          0: load_node(1'(ax), i, base + i * step);
          1: load_node(1'(ax), i, $urandom());
          default: load_node(1'(ax), i, base);
        endcase
  endtask

  task automatic accum(int px, int py, int pz);
    igb_in_t it;
    it = noise_item(FUNC_ACC);
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    send(it);
  endtask

  task automatic read(int cx, int cy);
    igb_in_t it;
    it = noise_item(FUNC_READ);
    it.cell_x = 5'(cx);
    it.cell_y = 5'(cy);
    send(it);
  endtask

  function automatic int near_coord(bit ax);
    int n, j, v;
    n = ax ? sb.eff_count(sb.y_used, MAX_Y_NODES) : sb.eff_count(sb.x_used, MAX_X_NODES);
    v = ax ? y_mirror[$urandom_range(n - 1)] : x_mirror[$urandom_range(n - 1)];
    if ($urandom_range(9) == 0) return v;
    j = 1 << $urandom_range(0, 24);
    return v + int'($urandom_range(0, 2 * j)) - j;
  endfunction

  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8)
        load_node(1'($urandom_range(1)), $urandom_range(31),
                  (r < 2) ? $urandom() : near_coord(r[0]));
      else if (r < 42)
        accum(($urandom_range(9) == 0) ? $urandom() : near_coord(1'b0),
              ($urandom_range(9) == 0) ? $urandom() : near_coord(1'b1), $urandom());
      else if (r < 72)
        read(sb.last_xi, sb.last_yi);
      else if (r < 86)
        read($urandom_range(31), $urandom_range(31));
      else if (r < 88)
        send(noise_item(FUNC_CLR));
      else if (r < 94)
        send(noise_item(3'($urandom_range(FUNC_LDX, FUNC_READ))));
      else
        send(noise_item(3'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI))));
    end
  endtask

  initial begin
    logic [5:0] xs [5];
    logic [5:0] ys [5];
    xs = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd0};
    ys = '{6'd32, 6'd2, 6'd1, 6'd17, 6'd0};
    xs[4] = 6'($urandom_range(63));
    ys[4] = 6'($urandom_range(63));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on a unit grid
    cfg_write(CFG_X_USED, 6'd32);
    cfg_write(CFG_Y_USED, 6'd32);
    load_grid(0, 0, 32'h0001_0000);
    accum(0, 0, 32'h7FFF_FFFF);
    read(0, 0);
    accum(0, 0, 32'h8000_0000);
    read(0, 0);
    accum(32'h0000_8000, 32'h0003_0000, 32'h0005_0000);  // x midway: first node wins
    read(0, 3);
    accum(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    read(31, 0);
    read(10, 10);
    send(noise_item(FUNC_NOP_LO));
    send(noise_item(FUNC_NOP_MID));
    send(noise_item(FUNC_NOP_HI));
    send(noise_item(FUNC_CLR));
    read(0, 0);
    // degenerate axis: every node at one coordinate
    load_grid(2, 32'h0007_0000, 0);
    accum(32'h0007_0000, 32'h0007_0000, 32'h0002_0000);
    accum(32'h0008_0000, 32'h0007_0000, 32'hFFFE_0000);
    read(0, 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      cfg_write(CFG_X_USED, xs[p]);
      cfg_write(CFG_Y_USED, ys[p]);
      if (p == 3) load_grid(1, 0, 0);
      else load_grid(0, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                     $urandom_range(1, 1 << (16 + p)));
      random_items(RAND_ITEMS);
      drain();
    end

    $display("covered %0d items: %0d accumulates, %0d checked reads, %0d clears,",
             items_sent, sb.accums, sb.reads_checked, sb.clears);
    $display("six node-count settings incl. clamped extremes, in %0d cycles", cyc);
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("[idw_grid_binning_core] OK");
    end else begin
      $display("%0d mismatches, %0d reads outstanding", sb.errors, sb.pending_reads.size());
      $display("[idw_grid_binning_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/igb_pkg.sv
sv/igb_div.sv
sv/igb_ctrl.sv
sv/igb_dpath.sv
sv/idw_grid_binning_core.sv
bench/tb_top.sv
